// ===== src/sorted_table_binary_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search block
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define STBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define STBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared widths, codes and types of the sorted table search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  localparam int unsigned KEY_W           = 20;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned HIT_W           = 20;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  // Operation codes carried by an input beat
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Search sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } srch_state_e;

  // Status of the search sequencer toward the top level
  typedef struct packed {
    logic busy;
    logic valid;
    logic found;
  } stbs_res_t;

endpackage

`default_nettype wire

// ===== src/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted key table with clear, append and binary search query operations.
// ----------------------------------------------------------------------------
// The host loads keys in ascending order with append beats, empties the table
// and the hit count with a clear beat, and looks a key up with a query beat;
// only a query returns a result beat (found flag, position, running hit count).
// Clear and append complete in the cycle of acceptance and the block can take
// the next beat right away. A query holds in_stall_o high while a sequencer
// probes the key RAM once per cycle through its single registered read port:
// a setup step when the query is accepted, up to log2(TABLE_DEPTH)+1 probes
// (none on an empty table), and a move of the result to the output register
// once that register is free. Keys in the table are not cleared; entries below
// the fill count are the only ones read, so no clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [OP_W-1:0]  operation_i,
  input  wire logic [KEY_W-1:0] key_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  found_o,
  output logic      [POS_W-1:0] position_o,
  output logic      [HIT_W-1:0] match_total_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]       count_q, count_d;
  logic [HIT_W-1:0]    hit_q, hit_d;
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic [POS_W-1:0]    position_q, position_d;
  logic [HIT_W-1:0]    total_q, total_d;

  logic                in_accept;
  logic                out_free;
  logic                take;
  logic                do_clear;
  logic                do_append;
  logic                do_query;
  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;
  stbs_res_t           srch_status;
  logic [AW-1:0]       srch_pos;
  logic [AW+POS_W-1:0] pos_ext;

  // Decode the accepted input beat
  assign in_stall_o = srch_status.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_query  = 1'b0;
    case (op_e'(operation_i))
      OP_CLEAR:  do_clear  = in_accept;
      OP_APPEND: do_append = in_accept;
      OP_QUERY:  do_query  = in_accept;
      default: begin
      end
    endcase
  end

  // Append writes at the fill count; a full table drops the key
  assign ram_we = do_append && (count_q < CW'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (key_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stbs_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (do_query),
    .key_i    (key_value_i),
    .count_i  (count_q),
    .take_i   (take),
    .rdata_i  (ram_rdata),
    .re_o     (ram_re),
    .raddr_o  (ram_raddr),
    .status_o (srch_status),
    .pos_o    (srch_pos)
  );

  // Move a finished search into the output register once it is free
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = srch_status.valid && out_free;
  assign pos_ext  = {{POS_W{1'b0}}, srch_pos};

  always_comb begin
    count_d     = count_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    position_d  = position_q;
    total_d     = total_q;
    if (do_clear) begin
      count_d = '0;
      hit_d   = '0;
    end
    if (ram_we) begin
      count_d = count_q + CW'(1);
    end
    if (take) begin
      if (srch_status.found && (hit_q != HIT_MAX)) begin
        hit_d = hit_q + HIT_W'(1);
      end
      out_valid_d = 1'b1;
      found_d     = srch_status.found;
      position_d  = pos_ext[POS_W-1:0];
      total_d     = hit_d;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload registers
  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    position_q <= position_d;
    total_q    <= total_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign position_o    = position_q;
  assign match_total_o = total_q;

endmodule

`default_nettype wire

// ===== src/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/stbs_search.sv =====
// ----------------------------------------------------------------------------
// stbs_search
// Binary search sequencer: one key RAM probe and one compare per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbs_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH),
  localparam int unsigned CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [CW-1:0]    count_i,
  input  wire logic             take_i,
  input  wire logic [KEY_W-1:0] rdata_i,
  output logic                  re_o,
  output logic      [AW-1:0]    raddr_o,
  output stbs_res_t             status_o,
  output logic      [AW-1:0]    pos_o
);

  srch_state_e      state_q, state_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;
  logic [CW-1:0]    mid_q, mid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             found_q, found_d;

  logic [CW-1:0]    first_sum;
  logic [CW:0]      sum_lt;
  logic [CW:0]      sum_gt;
  logic [CW-1:0]    lo_gt;

  // Candidate midpoints: the first from the fill count, the others for both compare outcomes from registered bounds
  assign first_sum = count_i - CW'(1);
  assign sum_lt    = {1'b0, lo_q} + {1'b0, mid_q} - (CW+1)'(1);
  assign sum_gt    = {1'b0, mid_q} + {1'b0, hi_q};
  assign lo_gt     = mid_q + CW'(1);

  // State and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
  end

  // Next state, bounds and probe address
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    found_d = found_q;
    re_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          found_d = 1'b0;
          lo_d    = '0;
          hi_d    = count_i;
          if (count_i == '0) begin
            mid_d   = '0;
            state_d = S_DONE;
          end else begin
            mid_d   = first_sum >> 1;
            re_o    = 1'b1;
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (key_q == rdata_i) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (key_q < rdata_i) begin
          if (lo_q < mid_q) begin
            hi_d  = mid_q;
            mid_d = sum_lt[CW:1];
            re_o  = 1'b1;
          end else begin
            mid_d   = '0;
            state_d = S_DONE;
          end
        end else begin
          if (lo_gt < hi_q) begin
            lo_d  = lo_gt;
            mid_d = sum_gt[CW:1];
            re_o  = 1'b1;
          end else begin
            mid_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Probe address follows the next midpoint, which stays below the depth
  assign raddr_o = mid_d[AW-1:0];

  assign status_o.busy  = (state_q != S_IDLE);
  assign status_o.valid = (state_q == S_DONE);
  assign status_o.found = found_q;
  assign pos_o          = mid_q[AW-1:0];

endmodule

`default_nettype wire

// ===== src/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the sorted table search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_table_binary_search_assert.svh"

module stbs_checker import stbs_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [OP_W-1:0]  operation_i,
  input wire logic [KEY_W-1:0] key_value_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             found_o,
  input wire logic [POS_W-1:0] position_o,
  input wire logic [HIT_W-1:0] match_total_o
);

  logic query_beat;
  logic out_held;

  assign query_beat = in_valid_i && !in_stall_o && (operation_i == OP_QUERY);
  assign out_held   = out_valid_o && out_stall_i;

  // A query beat is followed by a stall on the input
  `STBS_ASSERT_NEXT(a_query_stalls, clk_i, rst_ni, query_beat, in_stall_o, "query not held off")

  // A result beat only shows up after a search was running
  `STBS_ASSERT_IMPL(a_result_after_search, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without search")

  // A miss reports position zero
  `STBS_ASSERT_IMPL(a_miss_pos_zero, clk_i, rst_ni, out_valid_o && !found_o, position_o == '0, "miss with nonzero position")

  // A hit is counted in the running total
  `STBS_ASSERT_IMPL(a_hit_counted, clk_i, rst_ni, out_valid_o && found_o, match_total_o != '0, "hit not counted")

  // A stalled result beat holds its payload
  `STBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(found_o) && $stable(position_o) && $stable(match_total_o), "stalled result changed")

  logic unused_key;
  assign unused_key = ^key_value_i;

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

`default_nettype wire

// ===== tb/stbs_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_lookup_checker
// Watches both channels of the sorted table search block. It keeps a shadow
// key table, fill level and hit count, predicts each lookup beat from them
// and compares the result beats field by field, in order.
// ----------------------------------------------------------------------------

module stbs_lookup_checker import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [KEY_W-1:0] key_value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             found_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [HIT_W-1:0] match_total_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o,
  output int               hits_o
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [HIT_W-1:0] match_total;
  } lookup_result_t;

  // Shadow of the block's state
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  int unsigned      fill_level;
  logic [HIT_W-1:0] hit_total;

  lookup_result_t   pending_lookups [$];
  lookup_result_t   got;
  lookup_result_t   want;
  int               fails;
  int               results;
  int               hits;

  // Follow the probe sequence over the filled entries; position stays 0 on a miss
  function automatic lookup_result_t predict_lookup(input logic [KEY_W-1:0] key);
    lookup_result_t res;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    res = '0;
    lo  = 0;
    hi  = fill_level;
    while (lo < hi && !res.found) begin
      mid = lo + (hi - 1 - lo) / 2;
      if (key < key_mem[mid]) begin
        hi = mid;
      end else if (key > key_mem[mid]) begin
        lo = mid + 1;
      end else begin
        res.found    = 1'b1;
        res.position = mid[POS_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_level = 0;
      hit_total  = '0;
      fails      = 0;
      results    = 0;
      hits       = 0;
      pending_lookups.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      hits_o       <= 0;
    end else begin
      // Compare each result beat with the oldest lookup still waiting
      if (out_valid_i && !out_stall_i) begin
        if (pending_lookups.size() == 0) begin
          $error("result beat with no lookup waiting (found %0d, position %0d, total %0d)",
                 found_i, position_i, match_total_i);
          fails++;
        end else begin
          want = pending_lookups.pop_front();
          got  = '{found: found_i, position: position_i, match_total: match_total_i};
          results++;
          if (want.found) hits++;
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fails++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            fails++;
          end
          if (got.match_total !== want.match_total) begin
            $error("match_total: expected %0d, got %0d", want.match_total,
                   got.match_total);
            fails++;
          end
        end
      end

      // Advance the shadow state on each accepted input beat
      if (in_valid_i && !in_stall_i) begin
        case (operation_i)
          OP_CLEAR: begin
            fill_level = 0;
            hit_total  = '0;
          end
          OP_APPEND: begin
            // drop the key once the table is full
            if (fill_level < TABLE_DEPTH) begin
              key_mem[fill_level] = key_value_i;
              fill_level++;
            end
          end
          OP_QUERY: begin
            want = predict_lookup(key_value_i);
            if (want.found && hit_total != HIT_MAX) hit_total = hit_total + 1'b1;
            want.match_total = hit_total;
            pending_lookups.push_back(want);
          end
          default: ;
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= pending_lookups.size();
      results_o    <= results;
      hits_o       <= hits;
    end
  end

endmodule

// ===== tb/tb_sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search
// Drives clear, append and query beats into the sorted table search block:
// a directed opening, one pass that fills the table to capacity, then random
// loads and lookups mixed with noise. Both channels idle at random; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int unsigned      DEPTH          = TABLE_DEPTH_DEF;
  localparam int unsigned      KEY_TOP        = 999999;
  localparam logic [OP_W-1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned      SEARCH_LAT     = $clog2(DEPTH) + 3;
  localparam int               BEAT_TARGET    = 1250;
  localparam int               HOLD_CYCLES    = 300;
  localparam int               WATCHDOG_LIMIT = 4000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [OP_W-1:0]  operation_i = '0;
  logic [KEY_W-1:0] key_value_i = '0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             found_o;
  logic [POS_W-1:0] position_o;
  logic [HIT_W-1:0] match_total_o;

  int fail_count;
  int pending_lookups;
  int results_checked;
  int hits_seen;

  // Stimulus bookkeeping
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int          beats;
  int          n_clear;
  int          n_append;
  int          n_query;
  int          n_unused;
  int          idle_cycles;
  int unsigned loaded [$];

  always #5 clk_i = ~clk_i;

  sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .position_o    (position_o),
    .match_total_o (match_total_o)
  );

  stbs_lookup_checker #(.TABLE_DEPTH(DEPTH)) u_lookup_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .operation_i   (operation_i),
    .key_value_i   (key_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_i       (found_o),
    .position_i    (position_o),
    .match_total_i (match_total_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_lookups),
    .results_o     (results_checked),
    .hits_o        (hits_seen)
  );

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [OP_W-1:0] op, input int unsigned key);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_value_i <= key[KEY_W-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (op)
      OP_CLEAR: begin
        n_clear++;
        loaded.delete();
      end
      OP_APPEND: begin
        n_append++;
        loaded.push_back(key);
      end
      OP_QUERY: n_query++;
      default: n_unused++;
    endcase
    if (op != OP_UNUSED) beats++;
  endtask

  // Stop sending until every lookup result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups != 0) @(posedge clk_i);
  endtask

  // Append n keys: ascending, ascending with repeats, or in random order
  task automatic load_table(input int n, input bit dups, input bit shuffled);
    int unsigned span;
    int unsigned key;
    span = KEY_TOP / (n + 1);
    key  = $urandom_range(0, span);
    for (int i = 0; i < n; i++) begin
      if (shuffled) begin
        send_beat(OP_APPEND, $urandom_range(0, KEY_TOP));
      end else begin
        send_beat(OP_APPEND, key);
      end
      if (!(dups && $urandom_range(0, 2) == 0)) key += $urandom_range(1, span);
    end
  endtask

  // Query loaded keys, their neighbors and random keys
  task automatic run_queries(input int m);
    int unsigned key;
    int unsigned pick;
    for (int i = 0; i < m; i++) begin
      pick = $urandom_range(0, 9);
      key  = $urandom_range(0, KEY_TOP);
      if (pick < 8 && loaded.size() != 0) begin
        key = loaded[$urandom_range(0, loaded.size() - 1)];
        if (pick >= 6) begin
          if ($urandom_range(0, 1) && key < KEY_TOP) key++;
          else if (key > 0) key--;
        end
      end
      send_beat(OP_QUERY, key);
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL sorted_table_binary_search");
        $finish;
      end
    end
  end

  initial begin
    int               r;
    int               n;
    int               phase;
    logic [OP_W-1:0]  op;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, key extremes, hits and misses
    send_beat(OP_QUERY, 0);
    send_beat(OP_APPEND, 0);
    send_beat(OP_APPEND, 500000);
    send_beat(OP_APPEND, KEY_TOP);
    send_beat(OP_QUERY, 0);
    send_beat(OP_QUERY, KEY_TOP);
    send_beat(OP_QUERY, 500000);
    send_beat(OP_QUERY, 1);
    send_beat(OP_QUERY, KEY_TOP - 1);
    // unused operation must leave table and count alone
    send_beat(OP_UNUSED, KEY_TOP);
    send_beat(OP_UNUSED, 0);
    send_beat(OP_QUERY, 500000);
    // after clear the old entries are no longer searched
    send_beat(OP_CLEAR, 0);
    send_beat(OP_QUERY, 0);
    send_beat(OP_QUERY, 500000);
    // duplicate keys, then a key out of order
    send_beat(OP_APPEND, 7);
    send_beat(OP_APPEND, 7);
    send_beat(OP_APPEND, 7);
    send_beat(OP_QUERY, 7);
    send_beat(OP_APPEND, 3);
    send_beat(OP_QUERY, 3);
    send_beat(OP_QUERY, 8);
    send_beat(OP_CLEAR, KEY_TOP);
    wait_drained();

    // Fill the table to capacity with no idling, then push past the end
    calm = 1'b1;
    send_beat(OP_CLEAR, 0);
    load_table(DEPTH, 1'b0, 1'b0);
    repeat (3) send_beat(OP_APPEND, KEY_TOP);
    calm = 1'b0;
    // long receiver hold-off while lookups keep coming
    hold_req = 1'b1;
    send_beat(OP_QUERY, loaded[0]);
    send_beat(OP_QUERY, loaded[DEPTH - 1]);
    send_beat(OP_QUERY, KEY_TOP);
    run_queries(12);
    wait_drained();

    // Random part: mostly load-then-lookup phases, some noise
    phase = 0;
    while (beats < BEAT_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        if ($urandom_range(0, 4) != 0) send_beat(OP_CLEAR, $urandom_range(0, KEY_TOP));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 40);
        load_table(n, r == 7, 1'b0);
        if (phase == 3) hold_req = 1'b1;
        run_queries($urandom_range(4, 24));
        if ($urandom_range(0, 3) == 0) send_beat(OP_UNUSED, $urandom_range(0, KEY_TOP));
      end else begin
        repeat ($urandom_range(5, 20)) begin
          r  = $urandom_range(0, 15);
          op = (r == 0) ? OP_CLEAR : (r < 4) ? OP_UNUSED : (r < 10) ? OP_APPEND : OP_QUERY;
          send_beat(op, $urandom_range(0, KEY_TOP));
        end
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (2 * SEARCH_LAT) @(posedge clk_i);

    $display("Run covered %0d clears, %0d appends, %0d queries, %0d unused-op beats",
             n_clear, n_append, n_query, n_unused);
    $display("  %0d lookups checked (%0d hits), incl. a full table and a %0d-cycle hold-off",
             results_checked, hits_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS sorted_table_binary_search");
    end else begin
      $display("FAIL sorted_table_binary_search");
    end
    $finish;
  end

endmodule

// ===== sorted_table_binary_search.f =====
+incdir+src
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_search.sv
src/sorted_table_binary_search.sv
src/stbs_checker.sv
tb/stbs_lookup_checker.sv
tb/tb_sorted_table_binary_search.sv
